FILE: rtl/dnc_pkg.sv
// ============================================================================
// dnc_pkg
// Shared types, constants and channel tables for the dead/noisy channel
// monitor.
// ============================================================================
`default_nettype none

package dnc_pkg;

    // Geometry of the detector.
    localparam int N_ARMS     = 2;
    localparam int N_PLANES   = 5;
    localparam int N_CHAMBERS = 6;
    localparam int N_TYPES    = 3;
    localparam int N_ROWS     = N_ARMS * N_PLANES * N_CHAMBERS * N_TYPES;

    // Plane sums and divider widths.
    localparam int SUM_W  = 48;
    localparam int DIVS_W = 16;
    localparam int PIDX_W = 4;
    localparam int ROW_W  = 8;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Verdict codes.
    localparam logic [2:0] VERDICT_GOOD    = 3'd0;
    localparam logic [2:0] VERDICT_NO_STAT = 3'd1;
    localparam logic [2:0] VERDICT_NOISY   = 3'd2;
    localparam logic [2:0] VERDICT_DEAD    = 3'd3;
    localparam logic [2:0] VERDICT_NOT_CH  = 3'd4;

    // Channel type code of the anode wires.
    localparam logic [1:0] TYPE_WIRE = 2'd3;

    // Action codes.
    localparam logic ACTION_HIT      = 1'b0;
    localparam logic ACTION_CLASSIFY = 1'b1;

    // Divider operand selection.
    localparam logic DIV_SEL_AVG  = 1'b0;
    localparam logic DIV_SEL_DEAD = 1'b1;

    // Configuration register values.
    typedef struct packed {
        logic [15:0] dead_cut;
        logic [15:0] noise_cut;
        logic        only_strips;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic clr_we;
        logic cap;
        logic hit_wr;
        logic cnt_load;
        logic div_start;
        logic div_sel;
        logic avg_load;
        logic q2_load;
        logic prod_load;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_classify;
        logic item_ok;
        logic div_done;
        logic out_free;
    } sts_t;

    // Channels per chamber and type; zero for an address that is not a channel.
    function automatic logic [7:0] table_size(input logic [2:0] plane,
                                              input logic [2:0] chamber,
                                              input logic [1:0] ctype);
        logic       col;
        logic [7:0] strip;
        logic [7:0] wire_n;
        col    = (chamber == 3'd2) || (chamber == 3'd5);
        strip  = 8'd0;
        wire_n = 8'd0;
        case (plane)
            3'd0: begin strip = col ? 8'd97  : 8'd118; wire_n = col ? 8'd127 : 8'd165; end
            3'd1: begin strip = col ? 8'd108 : 8'd129; wire_n = col ? 8'd150 : 8'd181; end
            3'd2: begin strip = col ? 8'd114 : 8'd138; wire_n = col ? 8'd158 : 8'd196; end
            3'd3: begin strip = col ? 8'd127 : 8'd151; wire_n = col ? 8'd180 : 8'd213; end
            3'd4: begin strip = col ? 8'd151 : 8'd164; wire_n = col ? 8'd204 : 8'd226; end
            default: begin strip = 8'd0; wire_n = 8'd0; end
        endcase
        if (chamber > 3'd5) begin
            table_size = 8'd0;
        end else if (ctype == 2'd1 || ctype == 2'd2) begin
            table_size = strip;
        end else if (ctype == TYPE_WIRE) begin
            table_size = wire_n;
        end else begin
            table_size = 8'd0;
        end
    endfunction

    // Total channel count of one plane over all chambers and types.
    function automatic logic [DIVS_W-1:0] plane_total(input logic [2:0] plane);
        case (plane)
            3'd0: plane_total = 16'd2246;
            3'd1: plane_total = 16'd2488;
            3'd2: plane_total = 16'd2660;
            3'd3: plane_total = 16'd2928;
            3'd4: plane_total = 16'd3228;
            default: plane_total = 16'd1;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dnc_ram.sv
// ============================================================================
// dnc_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module dnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/dnc_div.sv
// ============================================================================
// dnc_div
// Restoring divider that retires one quotient bit per cycle.
// ============================================================================
`default_nettype none

module dnc_div #(
    parameter int N = 48,
    parameter int D = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [N-1:0] dividend,
    input  wire logic [D-1:0] divisor,
    output logic              done,
    output logic      [N-1:0] quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     quo_reg;
    logic [D-1:0]     rem_reg;
    logic [D-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D:0]       rem_sh;
    logic [D:0]       diff;
    logic             ge;

    // One trial subtraction per cycle.
    assign rem_sh = {rem_reg, quo_reg[N-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(N);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[D-1:0] : rem_sh[D-1:0];
                quo_reg <= {quo_reg[N-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/dnc_datapath.sv
// ============================================================================
// dnc_datapath
// Count store, plane sums, divider, threshold compare and result register.
// ============================================================================
`default_nettype none

module dnc_datapath #(
    parameter int MAX_CHANNELS = 256,
    parameter int COUNT_BITS   = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dnc_pkg::cmd_t  cmd,
    output dnc_pkg::sts_t       sts,
    input  wire dnc_pkg::cfg_t  cfg,
    input  wire logic           s_action,
    input  wire logic           s_arm,
    input  wire logic [2:0]     s_plane,
    input  wire logic [2:0]     s_chamber,
    input  wire logic [1:0]     s_channel_type,
    input  wire logic [7:0]     s_channel,
    input  wire logic           m_ready,
    output logic                m_valid,
    output logic      [2:0]     m_verdict,
    output logic                m_listed,
    output logic      [31:0]    m_hit_count,
    output logic      [31:0]    m_plane_average
);

    localparam int DEPTH = dnc_pkg::N_ROWS * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = dnc_pkg::SUM_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Captured item.
    logic       action_reg;
    logic       arm_reg;
    logic [2:0] plane_reg;
    logic [2:0] chamber_reg;
    logic [1:0] ctype_reg;
    logic [7:0] channel_reg;

    logic [7:0]               size;
    logic                     item_ok;
    logic [dnc_pkg::ROW_W-1:0] row;
    logic [AW-1:0]            idx;
    logic [dnc_pkg::PIDX_W-1:0] pidx;

    logic [AW-1:0]         clr_addr_reg;
    logic [AW-1:0]         waddr;
    logic                  we;
    logic [COUNT_BITS-1:0] wdata;
    logic [COUNT_BITS-1:0] rdata;

    logic [SW-1:0]         sums_reg [dnc_pkg::N_ARMS * dnc_pkg::N_PLANES];
    logic [COUNT_BITS-1:0] count_reg;
    logic [SW-1:0]         avg_reg;
    logic [SW-1:0]         q2_reg;
    logic [63:0]           prod_reg;

    logic [SW-1:0]             div_a;
    logic [dnc_pkg::DIVS_W-1:0] div_b;
    logic [dnc_pkg::DIVS_W-1:0] dcut;
    logic                      div_done;
    logic [SW-1:0]             div_q;

    logic [63:0] count64;
    logic [2:0]  verdict;
    logic        out_valid_reg;
    logic [2:0]  verdict_reg;
    logic        listed_reg;
    logic [31:0] hit_count_reg;
    logic [31:0] average_reg;

    // Capture the item on acceptance.
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            action_reg  <= s_action;
            arm_reg     <= s_arm;
            plane_reg   <= s_plane;
            chamber_reg <= s_chamber;
            ctype_reg   <= s_channel_type;
            channel_reg <= s_channel;
        end
    end

    // Channel check and store address.
    assign size    = dnc_pkg::table_size(plane_reg, chamber_reg, ctype_reg);
    assign item_ok = (size != 8'd0) && (channel_reg != 8'd0) && (channel_reg <= size);
    assign row     = ((({7'd0, arm_reg} * 8'd5 + {5'd0, plane_reg}) * 8'd6
                     + {5'd0, chamber_reg}) * 8'd3) + {6'd0, ctype_reg} - 8'd1;
    assign idx     = AW'(row) * AW'(MAX_CHANNELS) + AW'(channel_reg) - AW'(1);
    assign pidx    = dnc_pkg::PIDX_W'({3'd0, arm_reg} * 4'd5 + {1'd0, plane_reg});

    // Clearing sweep address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_we) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Count store write side: zeros while clearing, increment on a hit.
    assign we    = cmd.clr_we || (cmd.hit_wr && item_ok && (rdata != COUNT_MAX));
    assign waddr = cmd.clr_we ? clr_addr_reg : idx;
    assign wdata = cmd.clr_we ? '0 : rdata + COUNT_BITS'(1);

    dnc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_counts (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx),
        .rdata (rdata)
    );

    // Plane sums follow every counted hit and saturate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dnc_pkg::N_ARMS * dnc_pkg::N_PLANES; i++) begin
                sums_reg[i] <= '0;
            end
        end else if (cmd.hit_wr && item_ok && (rdata != COUNT_MAX)
                     && (sums_reg[pidx] != dnc_pkg::SUM_MAX)) begin
            sums_reg[pidx] <= sums_reg[pidx] + SW'(1);
        end
    end

    // Shared divider: plane average first, then average over the dead cut.
    assign dcut  = (cfg.dead_cut == 16'd0) ? 16'd1 : cfg.dead_cut;
    assign div_a = (cmd.div_sel == dnc_pkg::DIV_SEL_DEAD) ? div_q : sums_reg[pidx];
    assign div_b = (cmd.div_sel == dnc_pkg::DIV_SEL_DEAD) ? dcut
                                                         : dnc_pkg::plane_total(plane_reg);

    dnc_div #(
        .N (SW),
        .D (dnc_pkg::DIVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Operand registers for the verdict.
    always_ff @(posedge aclk) begin
        if (cmd.cnt_load) begin
            count_reg <= rdata;
        end
        if (cmd.avg_load) begin
            avg_reg <= div_q;
        end
        if (cmd.q2_load) begin
            q2_reg <= div_q;
        end
        if (cmd.prod_load) begin
            prod_reg <= 64'(avg_reg) * 64'(cfg.noise_cut);
        end
    end

    // Verdict in priority order: not a channel, no statistics, noisy, dead, good.
    assign count64 = 64'(count_reg);
    always_comb begin
        if (!item_ok) begin
            verdict = dnc_pkg::VERDICT_NOT_CH;
        end else if (avg_reg == '0) begin
            verdict = dnc_pkg::VERDICT_NO_STAT;
        end else if (count64 >= prod_reg) begin
            verdict = dnc_pkg::VERDICT_NOISY;
        end else if (count64 <= 64'(q2_reg)) begin
            verdict = dnc_pkg::VERDICT_DEAD;
        end else begin
            verdict = dnc_pkg::VERDICT_GOOD;
        end
    end

    // Result register, held until the receiver takes the item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            verdict_reg <= verdict;
            if (item_ok) begin
                listed_reg    <= (verdict != dnc_pkg::VERDICT_GOOD)
                                 && (!cfg.only_strips || (ctype_reg != dnc_pkg::TYPE_WIRE));
                hit_count_reg <= (|count64[63:32]) ? 32'hFFFF_FFFF : count64[31:0];
                average_reg   <= (|avg_reg[SW-1:32]) ? 32'hFFFF_FFFF : avg_reg[31:0];
            end else begin
                listed_reg    <= 1'b0;
                hit_count_reg <= 32'd0;
                average_reg   <= 32'd0;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_verdict       = verdict_reg;
    assign m_listed        = listed_reg;
    assign m_hit_count     = hit_count_reg;
    assign m_plane_average = average_reg;

    // Status to the controller.
    assign sts.clr_last    = (clr_addr_reg == AW'(DEPTH - 1));
    assign sts.is_classify = (action_reg == dnc_pkg::ACTION_CLASSIFY);
    assign sts.item_ok     = item_ok;
    assign sts.div_done    = div_done;
    assign sts.out_free    = !out_valid_reg || m_ready;

endmodule

`default_nettype wire

FILE: rtl/dnc_ctrl.sv
// ============================================================================
// dnc_ctrl
// Controller that sequences clearing, hit updates and classification.
// ============================================================================
`default_nettype none

module dnc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire dnc_pkg::sts_t sts,
    output dnc_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DATA,
        ST_DIV1,
        ST_DIV2,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap    = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (!sts.is_classify) begin
                    cmd.hit_wr = 1'b1;
                    state_next = ST_IDLE;
                end else if (!sts.item_ok) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.cnt_load  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = dnc_pkg::DIV_SEL_AVG;
                    state_next    = ST_DIV1;
                end
            end
            ST_DIV1: begin
                cmd.div_sel = dnc_pkg::DIV_SEL_DEAD;
                if (sts.div_done) begin
                    cmd.avg_load  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV2;
                end
            end
            ST_DIV2: begin
                cmd.div_sel = dnc_pkg::DIV_SEL_DEAD;
                if (sts.div_done) begin
                    cmd.q2_load = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.prod_load = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dead_noisy_channel_monitor.sv
// ============================================================================
// dead_noisy_channel_monitor
// Counts channel hits and classifies channels as good, dead, noisy, without statistics or not a channel.
// ============================================================================
// Usage:
// The s_ channel carries one item per handshake. A hit item (action 0)
// bumps the channel's saturating count and its plane sum and gives no
// result; the next item is accepted after the registered read and the
// write-back of the count memory. A classify item (action 1) gives one
// result on the m_ channel after one memory read, two passes of the shared
// bit-serial divider (plane average, then average over the dead cut), one
// multiply and the result load; the next item is accepted once the result
// is loaded. A classify item on a non-existent channel skips the divider
// and the multiply but still gives a result. After reset the count memory
// is swept to zero, one entry per cycle, over all 180*MAX_CHANNELS entries
// (46080 by default); s_ready stays low meanwhile. Plane sums and
// configuration registers reset at once. The result sits in an output
// register: a stalled receiver does not block further hit items, and only
// the next classify result waits for m_ready. Configuration is written
// through the APB port; the user must do so only while the block is idle,
// and the block itself does not enforce it.
// ============================================================================
`default_nettype none

module dead_noisy_channel_monitor #(
    parameter int MAX_CHANNELS = 256,
    parameter int COUNT_BITS   = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic        s_arm,
    input  wire logic [2:0]  s_plane,
    input  wire logic [2:0]  s_chamber,
    input  wire logic [1:0]  s_channel_type,
    input  wire logic [7:0]  s_channel,
    // Result channel.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [2:0]  m_verdict,
    output logic             m_listed,
    output logic      [31:0] m_hit_count,
    output logic      [31:0] m_plane_average,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam logic [1:0] REG_DEAD_CUT    = 2'd0;
    localparam logic [1:0] REG_NOISE_CUT   = 2'd1;
    localparam logic [1:0] REG_ONLY_STRIPS = 2'd2;

    dnc_pkg::cfg_t cfg_reg;
    dnc_pkg::cmd_t cmd;
    dnc_pkg::sts_t sts;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dead_cut    <= 16'd100;
            cfg_reg.noise_cut   <= 16'd9;
            cfg_reg.only_strips <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_DEAD_CUT:    cfg_reg.dead_cut    <= pwdata[15:0];
                REG_NOISE_CUT:   cfg_reg.noise_cut   <= pwdata[15:0];
                REG_ONLY_STRIPS: cfg_reg.only_strips <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_DEAD_CUT:    prdata = {16'd0, cfg_reg.dead_cut};
            REG_NOISE_CUT:   prdata = {16'd0, cfg_reg.noise_cut};
            REG_ONLY_STRIPS: prdata = {31'd0, cfg_reg.only_strips};
            default:         prdata = 32'd0;
        endcase
    end

    assign pready  = 1'b1;
    assign s_ready = cmd.in_ready;

    dnc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    dnc_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg             (cfg_reg),
        .s_action        (s_action),
        .s_arm           (s_arm),
        .s_plane         (s_plane),
        .s_chamber       (s_chamber),
        .s_channel_type  (s_channel_type),
        .s_channel       (s_channel),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_verdict       (m_verdict),
        .m_listed        (m_listed),
        .m_hit_count     (m_hit_count),
        .m_plane_average (m_plane_average)
    );

endmodule

`default_nettype wire
